### hdl/lens_distortion_forward_map_unit_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the lens distortion forward map unit
// Shared property shapes, clocked on clk and disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef LENS_DISTORTION_FORWARD_MAP_UNIT_DEFINES_SVH
`define LENS_DISTORTION_FORWARD_MAP_UNIT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define LDFM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define LDFM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/ldfm_pkg.sv
// ----------------------------------------------------------------------------
// ldfm_pkg
// Types, constants and helpers shared by the lens distortion forward map.
// ----------------------------------------------------------------------------
package ldfm_pkg;

	// Fixed point formats
	localparam int COORD_FRAC_BITS = 10;
	localparam int COEF_FRAC_BITS  = 20;

	// Field widths
	localparam int COORD_W = 24;
	localparam int FOC_W   = 24;
	localparam int COEF_W  = 24;
	localparam int TANG_W  = 48;
	localparam int IN_W    = 2 * COORD_W;
	localparam int OUT_W   = 2 * COORD_W;
	localparam int IDX_W   = 3;

	// Internal wide arithmetic: signed 64 bit, magnitude limited to 2^62-1
	localparam int WIDE_W = 64;
	localparam int MAG_W  = 62;
	localparam int HALF_W = MAG_W / 2;
	localparam int PROD_W = 2 * MAG_W;

	// Divider: |pixel - center| is up to 25 bits, shifted left by the fraction
	localparam int DIFF_W    = COORD_W + 1;
	localparam int DVD_W     = DIFF_W + COEF_FRAC_BITS;
	localparam int DIV_STEPS = DVD_W;

	// Arithmetic section after the divider, counted from its first register
	localparam int ARITH_STAGES = 24;
	localparam int NSTAGE       = 1 + DIV_STEPS + ARITH_STAGES;

	typedef logic signed [WIDE_W-1:0]  wide_t;
	typedef logic signed [COORD_W-1:0] coord_t;

	localparam wide_t LIMIT   = wide_t'(64'h3FFF_FFFF_FFFF_FFFF);
	localparam wide_t OUT_MAX = wide_t'((64'd1 << (COORD_W - 1)) - 64'd1);
	localparam wide_t OUT_MIN = -wide_t'(64'd1 << (COORD_W - 1));
	localparam wide_t ONE_Q   = wide_t'(64'd1 << COEF_FRAC_BITS);
	localparam logic [FOC_W-1:0] FOCAL_ONE = FOC_W'(1 << COORD_FRAC_BITS);

	// Register indexes on the configuration channel
	typedef enum logic [IDX_W-1:0] {
		REG_FOCAL_X    = 3'd0,
		REG_FOCAL_Y    = 3'd1,
		REG_CENTER_X   = 3'd2,
		REG_CENTER_Y   = 3'd3,
		REG_RADIAL_K1  = 3'd4,
		REG_RADIAL_K2  = 3'd5,
		REG_RADIAL_K3  = 3'd6,
		REG_TANGENTIAL = 3'd7
	} reg_idx_t;

	// Add two limited values and clamp the sum back to +-(2^62-1)
	function automatic wide_t sat_add(wide_t a, wide_t b);
		wide_t s;
		s = a + b;
		if (s > LIMIT)
			s = LIMIT;
		else if (s < -LIMIT)
			s = -LIMIT;
		return s;
	endfunction

endpackage

### hdl/ldfm_mulq.sv
// ----------------------------------------------------------------------------
// ldfm_mulq
// Three stage saturating fixed point multiplier: (a * b) >> COEF_FRAC_BITS,
// magnitude truncated, clamped to +-(2^62-1). Split into four 31x31 products.
// ----------------------------------------------------------------------------
module ldfm_mulq (
	input  logic           clk,
	input  logic           en,
	input  ldfm_pkg::wide_t a,
	input  ldfm_pkg::wide_t b,
	output ldfm_pkg::wide_t p
);

	ldfm_pkg::wide_t a_mag;
	ldfm_pkg::wide_t b_mag;
	logic [2*ldfm_pkg::HALF_W-1:0] pp00_s1, pp01_s1, pp10_s1, pp11_s1;
	logic                          neg_s1, neg_s2;
	logic [ldfm_pkg::PROD_W-1:0]   full_s2;
	logic                          sat;
	logic [ldfm_pkg::MAG_W-1:0]    mag_res;

	// Take magnitudes of both operands
	assign a_mag = a[ldfm_pkg::WIDE_W-1] ? -a : a;
	assign b_mag = b[ldfm_pkg::WIDE_W-1] ? -b : b;

	// Stage 1: partial products
	always_ff @(posedge clk) begin
		if (en) begin
			pp00_s1 <= a_mag[ldfm_pkg::HALF_W-1:0] * b_mag[ldfm_pkg::HALF_W-1:0];
			pp01_s1 <= a_mag[ldfm_pkg::HALF_W-1:0] *
				b_mag[ldfm_pkg::MAG_W-1:ldfm_pkg::HALF_W];
			pp10_s1 <= a_mag[ldfm_pkg::MAG_W-1:ldfm_pkg::HALF_W] *
				b_mag[ldfm_pkg::HALF_W-1:0];
			pp11_s1 <= a_mag[ldfm_pkg::MAG_W-1:ldfm_pkg::HALF_W] *
				b_mag[ldfm_pkg::MAG_W-1:ldfm_pkg::HALF_W];
			neg_s1  <= a[ldfm_pkg::WIDE_W-1] ^ b[ldfm_pkg::WIDE_W-1];
		end
	end

	// Stage 2: assemble the full product
	always_ff @(posedge clk) begin
		if (en) begin
			full_s2 <= (ldfm_pkg::PROD_W'(pp11_s1) << (2 * ldfm_pkg::HALF_W)) +
				((ldfm_pkg::PROD_W'(pp01_s1) + ldfm_pkg::PROD_W'(pp10_s1))
					<< ldfm_pkg::HALF_W) +
				ldfm_pkg::PROD_W'(pp00_s1);
			neg_s2  <= neg_s1;
		end
	end

	// Stage 3: drop the fraction, clamp and restore the sign
	assign sat = |full_s2[ldfm_pkg::PROD_W-1:ldfm_pkg::MAG_W+ldfm_pkg::COEF_FRAC_BITS];
	assign mag_res = sat ? ldfm_pkg::LIMIT[ldfm_pkg::MAG_W-1:0] :
		full_s2[ldfm_pkg::MAG_W+ldfm_pkg::COEF_FRAC_BITS-1:ldfm_pkg::COEF_FRAC_BITS];

	always_ff @(posedge clk) begin
		if (en) begin
			if (neg_s2)
				p <= -ldfm_pkg::wide_t'({2'b00, mag_res});
			else
				p <= ldfm_pkg::wide_t'({2'b00, mag_res});
		end
	end

endmodule

### hdl/lens_distortion_forward_map_unit.sv
// ----------------------------------------------------------------------------
// lens_distortion_forward_map_unit
// Forward Brown-Conrady distortion (k1 k2 k3 radial, p1 p2 tangential) of one
// Q14.10 pixel pair per clock while no output beat is parked, fully pipelined.
// ----------------------------------------------------------------------------
// Channel   Direction  Beat contents
// s_axis    in         tdata: pixel_x, pixel_y
// m_axis    out        tdata: warped_x, warped_y; tuser: saturated
// cfg       in         cfg_index selects register, cfg_data holds the value
//
// One beat per clock in and out while the skid register is empty. There is
// one input stage, then 45 restoring divider steps (one quotient bit each),
// 24 arithmetic stages built around three stage multipliers, and the output
// register. Reset clears every valid bit and loads the register reset values.
// A stalled output beat lands in a skid register; while it is full the whole
// pipeline freezes and s_axis_tready is low, so nothing is lost or repeated.
// ----------------------------------------------------------------------------
`include "lens_distortion_forward_map_unit_defines.svh"

module lens_distortion_forward_map_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [ldfm_pkg::IN_W-1:0]     s_axis_tdata,  // pixel_x [23:0], pixel_y [47:24]
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [ldfm_pkg::OUT_W-1:0]    m_axis_tdata,  // warped_x [23:0], warped_y [47:24]
	output logic                          m_axis_tuser,  // saturated [0]
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [ldfm_pkg::IDX_W-1:0]    cfg_index,
	input  logic [ldfm_pkg::TANG_W-1:0]   cfg_data
);

	// Configuration registers
	logic [ldfm_pkg::FOC_W-1:0]   focal_x_q, focal_y_q;
	ldfm_pkg::coord_t             center_x_q, center_y_q;
	logic signed [ldfm_pkg::COEF_W-1:0] radial_k1_q, radial_k2_q, radial_k3_q;
	logic [ldfm_pkg::TANG_W-1:0]  tangential_q;

	logic [ldfm_pkg::FOC_W-1:0]   fx_eff, fy_eff;
	logic signed [ldfm_pkg::COEF_W-1:0] p1, p2;
	ldfm_pkg::wide_t k1_w, k2_w, k3_w, p1_w, p2_w, fx_w, fy_w, cx_w, cy_w;

	// Pipeline control
	logic                          en;
	logic [ldfm_pkg::NSTAGE-1:0]   vld_s;

	// Input stage and divider
	ldfm_pkg::coord_t               pix_x, pix_y;
	logic signed [ldfm_pkg::DIFF_W-1:0] diff_x, diff_y;
	logic [ldfm_pkg::DIFF_W-1:0]    dmag_x, dmag_y;
	logic [ldfm_pkg::FOC_W-1:0]     div_rem_x_s [0:ldfm_pkg::DIV_STEPS];
	logic [ldfm_pkg::FOC_W-1:0]     div_rem_y_s [0:ldfm_pkg::DIV_STEPS];
	logic [ldfm_pkg::DVD_W-1:0]     div_dq_x_s  [0:ldfm_pkg::DIV_STEPS];
	logic [ldfm_pkg::DVD_W-1:0]     div_dq_y_s  [0:ldfm_pkg::DIV_STEPS];
	logic                           div_neg_x_s [0:ldfm_pkg::DIV_STEPS];
	logic                           div_neg_y_s [0:ldfm_pkg::DIV_STEPS];

	// Arithmetic section, suffix counts stages after the divider
	ldfm_pkg::wide_t xn_dl [0:14];
	ldfm_pkg::wide_t yn_dl [0:14];
	ldfm_pkg::wide_t x2_s3, y2_s3, xy_s3;
	ldfm_pkg::wide_t r2_s4, x2x2_s4, y2y2_s4, r2_s5, r2_s6, r2_s7;
	ldfm_pkg::wide_t ex_s5, ey_s5;
	ldfm_pkg::wide_t t1_s6, t2_s6, tt1_s7, tt2_s7, tt1_s8, tt2_s8;
	ldfm_pkg::wide_t r4_s7, k1r2_s7, p2ex_s8, p1ey_s8;
	ldfm_pkg::wide_t ra1_s8, ra1_s9, ra1_s10, r6_s10, k2r4_s10;
	ldfm_pkg::wide_t ra2_s11, ra2_s12, ra2_s13, k3r6_s13, ra_s14;
	ldfm_pkg::wide_t dx_dl [9:17];
	ldfm_pkg::wide_t dy_dl [9:17];
	ldfm_pkg::wide_t xnra_s17, ynra_s17, xd_s18, yd_s18, bx_s21, by_s21;
	ldfm_pkg::wide_t sx_s22, sy_s22;
	ldfm_pkg::coord_t wx_s23, wy_s23;
	logic             sat_s23;
	logic             clip_x, clip_y;
	ldfm_pkg::coord_t wx_c, wy_c;

	// Output register and skid
	logic                        out_valid_q, skid_valid_q;
	logic [ldfm_pkg::OUT_W-1:0]  out_data_q, skid_data_q;
	logic                        out_sat_q, skid_sat_q;
	logic                        take, incoming, load_out, load_skid;

	// ------------------------------------------------------------------
	// Configuration
	// ------------------------------------------------------------------
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q    <= ldfm_pkg::FOCAL_ONE;
			focal_y_q    <= ldfm_pkg::FOCAL_ONE;
			center_x_q   <= '0;
			center_y_q   <= '0;
			radial_k1_q  <= '0;
			radial_k2_q  <= '0;
			radial_k3_q  <= '0;
			tangential_q <= '0;
		end else if (cfg_valid) begin
			unique case (ldfm_pkg::reg_idx_t'(cfg_index))
				ldfm_pkg::REG_FOCAL_X:    focal_x_q    <= cfg_data[ldfm_pkg::FOC_W-1:0];
				ldfm_pkg::REG_FOCAL_Y:    focal_y_q    <= cfg_data[ldfm_pkg::FOC_W-1:0];
				ldfm_pkg::REG_CENTER_X:   center_x_q   <= cfg_data[ldfm_pkg::COORD_W-1:0];
				ldfm_pkg::REG_CENTER_Y:   center_y_q   <= cfg_data[ldfm_pkg::COORD_W-1:0];
				ldfm_pkg::REG_RADIAL_K1:  radial_k1_q  <= cfg_data[ldfm_pkg::COEF_W-1:0];
				ldfm_pkg::REG_RADIAL_K2:  radial_k2_q  <= cfg_data[ldfm_pkg::COEF_W-1:0];
				ldfm_pkg::REG_RADIAL_K3:  radial_k3_q  <= cfg_data[ldfm_pkg::COEF_W-1:0];
				ldfm_pkg::REG_TANGENTIAL: tangential_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Zero focal length acts as one LSB
	assign fx_eff = (focal_x_q == '0) ? ldfm_pkg::FOC_W'(1) : focal_x_q;
	assign fy_eff = (focal_y_q == '0) ? ldfm_pkg::FOC_W'(1) : focal_y_q;

	assign p1 = tangential_q[ldfm_pkg::TANG_W-1:ldfm_pkg::COEF_W];
	assign p2 = tangential_q[ldfm_pkg::COEF_W-1:0];

	// Widen coefficients to the internal format
	assign k1_w = ldfm_pkg::wide_t'(radial_k1_q);
	assign k2_w = ldfm_pkg::wide_t'(radial_k2_q);
	assign k3_w = ldfm_pkg::wide_t'(radial_k3_q);
	assign p1_w = ldfm_pkg::wide_t'(p1);
	assign p2_w = ldfm_pkg::wide_t'(p2);
	assign fx_w = ldfm_pkg::wide_t'({1'b0, fx_eff});
	assign fy_w = ldfm_pkg::wide_t'({1'b0, fy_eff});
	assign cx_w = ldfm_pkg::wide_t'(center_x_q);
	assign cy_w = ldfm_pkg::wide_t'(center_y_q);

	// ------------------------------------------------------------------
	// Pipeline enable and valid bits
	// ------------------------------------------------------------------
	assign en            = !skid_valid_q;
	assign s_axis_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s <= '0;
		else if (en)
			vld_s <= {vld_s[ldfm_pkg::NSTAGE-2:0], s_axis_tvalid};
	end

	// ------------------------------------------------------------------
	// Input stage: offset by the principal point, split sign and magnitude
	// ------------------------------------------------------------------
	assign pix_x  = s_axis_tdata[ldfm_pkg::COORD_W-1:0];
	assign pix_y  = s_axis_tdata[ldfm_pkg::IN_W-1:ldfm_pkg::COORD_W];
	assign diff_x = ldfm_pkg::DIFF_W'(pix_x) - ldfm_pkg::DIFF_W'(center_x_q);
	assign diff_y = ldfm_pkg::DIFF_W'(pix_y) - ldfm_pkg::DIFF_W'(center_y_q);
	assign dmag_x = diff_x[ldfm_pkg::DIFF_W-1] ? -diff_x : diff_x;
	assign dmag_y = diff_y[ldfm_pkg::DIFF_W-1] ? -diff_y : diff_y;

	always_ff @(posedge clk) begin
		if (en) begin
			div_rem_x_s[0] <= '0;
			div_rem_y_s[0] <= '0;
			div_dq_x_s[0]  <= {dmag_x, {ldfm_pkg::COEF_FRAC_BITS{1'b0}}};
			div_dq_y_s[0]  <= {dmag_y, {ldfm_pkg::COEF_FRAC_BITS{1'b0}}};
			div_neg_x_s[0] <= diff_x[ldfm_pkg::DIFF_W-1];
			div_neg_y_s[0] <= diff_y[ldfm_pkg::DIFF_W-1];
		end
	end

	// ------------------------------------------------------------------
	// Restoring divider, one quotient bit per stage; quotient shifts in
	// at the bottom as dividend bits leave at the top
	// ------------------------------------------------------------------
	for (genvar k = 1; k <= ldfm_pkg::DIV_STEPS; k++) begin : g_div
		logic [ldfm_pkg::FOC_W:0] trial_x, trial_y, sub_x, sub_y;
		logic                     ge_x, ge_y;

		assign trial_x = {div_rem_x_s[k-1], div_dq_x_s[k-1][ldfm_pkg::DVD_W-1]};
		assign trial_y = {div_rem_y_s[k-1], div_dq_y_s[k-1][ldfm_pkg::DVD_W-1]};
		assign sub_x   = trial_x - {1'b0, fx_eff};
		assign sub_y   = trial_y - {1'b0, fy_eff};
		assign ge_x    = trial_x >= {1'b0, fx_eff};
		assign ge_y    = trial_y >= {1'b0, fy_eff};

		always_ff @(posedge clk) begin
			if (en) begin
				div_rem_x_s[k] <= ge_x ? sub_x[ldfm_pkg::FOC_W-1:0] :
					trial_x[ldfm_pkg::FOC_W-1:0];
				div_rem_y_s[k] <= ge_y ? sub_y[ldfm_pkg::FOC_W-1:0] :
					trial_y[ldfm_pkg::FOC_W-1:0];
				div_dq_x_s[k]  <= {div_dq_x_s[k-1][ldfm_pkg::DVD_W-2:0], ge_x};
				div_dq_y_s[k]  <= {div_dq_y_s[k-1][ldfm_pkg::DVD_W-2:0], ge_y};
				div_neg_x_s[k] <= div_neg_x_s[k-1];
				div_neg_y_s[k] <= div_neg_y_s[k-1];
			end
		end
	end

	// ------------------------------------------------------------------
	// Stage 0: signed normalised coordinates, and their delay lines
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (en) begin
			if (div_neg_x_s[ldfm_pkg::DIV_STEPS])
				xn_dl[0] <= -ldfm_pkg::wide_t'({{(ldfm_pkg::WIDE_W-ldfm_pkg::DVD_W){1'b0}},
					div_dq_x_s[ldfm_pkg::DIV_STEPS]});
			else
				xn_dl[0] <= ldfm_pkg::wide_t'({{(ldfm_pkg::WIDE_W-ldfm_pkg::DVD_W){1'b0}},
					div_dq_x_s[ldfm_pkg::DIV_STEPS]});
			if (div_neg_y_s[ldfm_pkg::DIV_STEPS])
				yn_dl[0] <= -ldfm_pkg::wide_t'({{(ldfm_pkg::WIDE_W-ldfm_pkg::DVD_W){1'b0}},
					div_dq_y_s[ldfm_pkg::DIV_STEPS]});
			else
				yn_dl[0] <= ldfm_pkg::wide_t'({{(ldfm_pkg::WIDE_W-ldfm_pkg::DVD_W){1'b0}},
					div_dq_y_s[ldfm_pkg::DIV_STEPS]});
			for (int i = 1; i <= 14; i++) begin
				xn_dl[i] <= xn_dl[i-1];
				yn_dl[i] <= yn_dl[i-1];
			end
		end
	end

	// Squares and cross term (stage 0 to 3)
	ldfm_mulq u_mul_x2 (.clk(clk), .en(en), .a(xn_dl[0]), .b(xn_dl[0]), .p(x2_s3));
	ldfm_mulq u_mul_y2 (.clk(clk), .en(en), .a(yn_dl[0]), .b(yn_dl[0]), .p(y2_s3));
	ldfm_mulq u_mul_xy (.clk(clk), .en(en), .a(xn_dl[0]), .b(yn_dl[0]), .p(xy_s3));

	// Tangential cross products (stage 3 to 6)
	ldfm_mulq u_mul_t1 (.clk(clk), .en(en), .a(p1_w), .b(xy_s3), .p(t1_s6));
	ldfm_mulq u_mul_t2 (.clk(clk), .en(en), .a(p2_w), .b(xy_s3), .p(t2_s6));

	// Radius powers and first radial term
	ldfm_mulq u_mul_r4   (.clk(clk), .en(en), .a(r2_s4), .b(r2_s4), .p(r4_s7));
	ldfm_mulq u_mul_k1r2 (.clk(clk), .en(en), .a(k1_w), .b(r2_s4), .p(k1r2_s7));
	ldfm_mulq u_mul_r6   (.clk(clk), .en(en), .a(r4_s7), .b(r2_s7), .p(r6_s10));
	ldfm_mulq u_mul_k2r4 (.clk(clk), .en(en), .a(k2_w), .b(r4_s7), .p(k2r4_s10));
	ldfm_mulq u_mul_k3r6 (.clk(clk), .en(en), .a(k3_w), .b(r6_s10), .p(k3r6_s13));

	// Tangential square terms (stage 5 to 8)
	ldfm_mulq u_mul_p2ex (.clk(clk), .en(en), .a(p2_w), .b(ex_s5), .p(p2ex_s8));
	ldfm_mulq u_mul_p1ey (.clk(clk), .en(en), .a(p1_w), .b(ey_s5), .p(p1ey_s8));

	// Radial scaling (stage 14 to 17)
	ldfm_mulq u_mul_xnra (.clk(clk), .en(en), .a(xn_dl[14]), .b(ra_s14), .p(xnra_s17));
	ldfm_mulq u_mul_ynra (.clk(clk), .en(en), .a(yn_dl[14]), .b(ra_s14), .p(ynra_s17));

	// Back to pixels (stage 18 to 21)
	ldfm_mulq u_mul_bx (.clk(clk), .en(en), .a(xd_s18), .b(fx_w), .p(bx_s21));
	ldfm_mulq u_mul_by (.clk(clk), .en(en), .a(yd_s18), .b(fy_w), .p(by_s21));

	// ------------------------------------------------------------------
	// Saturating adds and delay registers between the multipliers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (en) begin
			r2_s4   <= ldfm_pkg::sat_add(x2_s3, y2_s3);
			x2x2_s4 <= ldfm_pkg::sat_add(x2_s3, x2_s3);
			y2y2_s4 <= ldfm_pkg::sat_add(y2_s3, y2_s3);

			ex_s5   <= ldfm_pkg::sat_add(r2_s4, x2x2_s4);
			ey_s5   <= ldfm_pkg::sat_add(r2_s4, y2y2_s4);
			r2_s5   <= r2_s4;
			r2_s6   <= r2_s5;
			r2_s7   <= r2_s6;

			tt1_s7  <= ldfm_pkg::sat_add(t1_s6, t1_s6);
			tt2_s7  <= ldfm_pkg::sat_add(t2_s6, t2_s6);
			tt1_s8  <= tt1_s7;
			tt2_s8  <= tt2_s7;

			ra1_s8  <= ldfm_pkg::sat_add(ldfm_pkg::ONE_Q, k1r2_s7);
			ra1_s9  <= ra1_s8;
			ra1_s10 <= ra1_s9;

			dx_dl[9] <= ldfm_pkg::sat_add(tt1_s8, p2ex_s8);
			dy_dl[9] <= ldfm_pkg::sat_add(p1ey_s8, tt2_s8);
			for (int i = 10; i <= 17; i++) begin
				dx_dl[i] <= dx_dl[i-1];
				dy_dl[i] <= dy_dl[i-1];
			end

			ra2_s11 <= ldfm_pkg::sat_add(ra1_s10, k2r4_s10);
			ra2_s12 <= ra2_s11;
			ra2_s13 <= ra2_s12;
			ra_s14  <= ldfm_pkg::sat_add(ra2_s13, k3r6_s13);

			xd_s18  <= ldfm_pkg::sat_add(xnra_s17, dx_dl[17]);
			yd_s18  <= ldfm_pkg::sat_add(ynra_s17, dy_dl[17]);

			sx_s22  <= ldfm_pkg::sat_add(bx_s21, cx_w);
			sy_s22  <= ldfm_pkg::sat_add(by_s21, cy_w);
		end
	end

	// ------------------------------------------------------------------
	// Stage 23: clip to the 24 bit output range
	// ------------------------------------------------------------------
	always_comb begin
		clip_x = 1'b0;
		clip_y = 1'b0;
		wx_c   = ldfm_pkg::COORD_W'(sx_s22);
		wy_c   = ldfm_pkg::COORD_W'(sy_s22);
		if (sx_s22 > ldfm_pkg::OUT_MAX) begin
			clip_x = 1'b1;
			wx_c   = ldfm_pkg::COORD_W'(ldfm_pkg::OUT_MAX);
		end else if (sx_s22 < ldfm_pkg::OUT_MIN) begin
			clip_x = 1'b1;
			wx_c   = ldfm_pkg::COORD_W'(ldfm_pkg::OUT_MIN);
		end
		if (sy_s22 > ldfm_pkg::OUT_MAX) begin
			clip_y = 1'b1;
			wy_c   = ldfm_pkg::COORD_W'(ldfm_pkg::OUT_MAX);
		end else if (sy_s22 < ldfm_pkg::OUT_MIN) begin
			clip_y = 1'b1;
			wy_c   = ldfm_pkg::COORD_W'(ldfm_pkg::OUT_MIN);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			wx_s23  <= wx_c;
			wy_s23  <= wy_c;
			sat_s23 <= clip_x | clip_y;
		end
	end

	// ------------------------------------------------------------------
	// Output register with skid: park a beat the sink did not take
	// ------------------------------------------------------------------
	assign take      = out_valid_q & m_axis_tready;
	assign incoming  = en & vld_s[ldfm_pkg::NSTAGE-1];
	assign load_out  = skid_valid_q ? take : (incoming & (!out_valid_q | take));
	assign load_skid = !skid_valid_q & incoming & out_valid_q & !take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (skid_valid_q) begin
				skid_valid_q <= !take;
			end else begin
				skid_valid_q <= load_skid;
				if (incoming)
					out_valid_q <= 1'b1;
				else if (take)
					out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_data_q <= skid_valid_q ? skid_data_q : {wy_s23, wx_s23};
			out_sat_q  <= skid_valid_q ? skid_sat_q : sat_s23;
		end
		if (load_skid) begin
			skid_data_q <= {wy_s23, wx_s23};
			skid_sat_q  <= sat_s23;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_sat_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	`LDFM_ASSERT_NOW(a_skid_needs_out, skid_valid_q, out_valid_q, "skid full with output empty")
	`LDFM_ASSERT_NEXT(a_stall_fills_skid, incoming && out_valid_q && !m_axis_tready, skid_valid_q, "stalled beat not parked")
	`LDFM_ASSERT_NEXT(a_skid_freezes_pipe, skid_valid_q, $stable(vld_s), "pipeline moved while skid full")

endmodule
